[src/sfap_pkg.sv]
package sfap_pkg;

    localparam int ACC_W = 40;
    localparam int PROD_W = 48;
    localparam int TV_W = 24;
    localparam int CFG_W = 8;
    localparam int FRAME_W = 8;
    localparam int ORI_W = 3;

    localparam logic [0:0] REG_FPS = 1'b0;
    localparam logic [0:0] REG_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] FPS_RESET = 8'd10;
    localparam logic [CFG_W-1:0] COUNT_RESET = 8'd1;

    localparam int X_W = 15;
    localparam int Y_W = 13;
    localparam int Y_BIAS = 576;

endpackage

[src/sprite_frame_advance_and_place.sv]
// A bad orientation gives an all-zero result without any arithmetic. When no frame advance is due
// and a frame is already shown, only the first divide runs; otherwise all three divides run.
// One request at a time: a request is taken only once the previous result has been accepted.
// The fps*acc product is formed by shift/add one bit per cycle, and a shared shift/subtract
// divider, one bit per cycle, then does the divides.
// Reset clears accumulators, frame index and shown frame and loads the register defaults.
module sprite_frame_advance_and_place #(
    parameter int ORIENTATIONS = 6,
    parameter int TILE_GRID = 100,
    parameter int HEX_GRID = 200
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  orientation,
    input  logic [23:0] time_value,
    input  logic [23:0] time_scale,
    input  logic [7:0]  hex_x,
    input  logic [7:0]  hex_y,
    input  logic signed [7:0] shift_x,
    input  logic signed [7:0] shift_y,
    input  logic [15:0] draw_order,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        switched,
    output logic        hide_old,
    output logic [2:0]  old_orientation,
    output logic [7:0]  old_frame,
    output logic [2:0]  new_orientation,
    output logic [7:0]  new_frame,
    output logic [15:0] order_out,
    output logic signed [14:0] screen_x,
    output logic signed [12:0] screen_y
);

    localparam int S_RAW = HEX_GRID / TILE_GRID;
    localparam int S = (S_RAW == 0) ? 1 : S_RAW;
    localparam int PW = sfap_pkg::PROD_W;
    localparam int AW = sfap_pkg::ACC_W;
    localparam int CW = $clog2(PW + 1);
    localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(S) - 64'd1) / 64'(S));

    typedef logic signed [sfap_pkg::X_W-1:0] screen_x_t;
    typedef logic signed [sfap_pkg::Y_W-1:0] screen_y_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_DIV1, ST_DECIDE, ST_DIV2, ST_FINISH, ST_MOD,
        ST_PLACE, ST_DIVP, ST_OUT
    } state_t;

    state_t state_reg;
    logic [7:0] fps_reg, count_reg;
    logic [AW-1:0] acc_mem [ORIENTATIONS];
    logic [7:0] frame_reg;
    logic shown_valid_reg;
    logic [2:0] shown_ori_reg;
    logic [7:0] shown_frame_reg;

    logic [2:0] ori_reg;
    logic [23:0] scale_reg;
    logic [7:0] hx_reg, hy_reg;
    logic signed [7:0] sx_reg, sy_reg;
    logic [15:0] order_reg;
    logic [AW-1:0] acc_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] quo_reg;
    logic [PW:0] rem_reg;
    logic [PW-1:0] dvd_reg;
    logic [PW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] adv_reg;
    logic signed [16:0] px_reg, py_reg;
    logic px_done_reg;

    logic [PW:0] trial;
    logic [PW:0] rem_sh;
    logic [7:0] cnt_eff;
    logic [PW-1:0] mod_sum;
    logic signed [16:0] px_raw, py_raw;
    logic signed [16:0] pdiv_num;
    logic [16:0] pdiv_mag;
    logic [49:0] pdiv_prod;
    logic [16:0] pdiv_abs_q;
    logic signed [16:0] pdiv_q;
    logic odd;

    assign rem_sh = {rem_reg[PW-1:0], dvd_reg[PW-1]};
    assign trial = rem_sh - {1'b0, dvs_reg};
    assign cnt_eff = (count_reg == 8'd0) ? 8'd1 : count_reg;
    assign mod_sum = adv_reg + {{(PW - 8){1'b0}}, frame_reg};
    assign odd = hx_reg[0];
    assign px_raw = 17'(48 * int'(hx_reg) + 32 * int'(hy_reg));
    assign py_raw = 17'(24 * int'(hy_reg) + 12 * (TILE_GRID - 1 - int'(hx_reg)));
    assign pdiv_num = px_done_reg ? py_reg : px_reg;
    assign pdiv_mag = pdiv_num[16] ? 17'(-pdiv_num) : 17'(pdiv_num);
    assign pdiv_prod = 50'(pdiv_mag) * 50'(RECIP);
    assign pdiv_abs_q = pdiv_prod[48:32];
    assign pdiv_q = pdiv_num[16] ? -$signed(pdiv_abs_q) : $signed(pdiv_abs_q);
    assign in_ready = (state_reg == ST_IDLE) && !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fps_reg <= sfap_pkg::FPS_RESET;
            count_reg <= sfap_pkg::COUNT_RESET;
            for (int i = 0; i < ORIENTATIONS; i++)
            begin
                acc_mem[i] <= '0;
            end
            frame_reg <= '0;
            shown_valid_reg <= 1'b0;
            shown_ori_reg <= '0;
            shown_frame_reg <= '0;
            out_valid <= 1'b0;
            switched <= 1'b0;
            hide_old <= 1'b0;
            old_orientation <= '0;
            old_frame <= '0;
            new_orientation <= '0;
            new_frame <= '0;
            order_out <= '0;
            screen_x <= '0;
            screen_y <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sfap_pkg::REG_FPS:   fps_reg <= cfg_data;
                    sfap_pkg::REG_COUNT: count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        ori_reg <= orientation;
                        scale_reg <= time_scale;
                        hx_reg <= hex_x;
                        hy_reg <= hex_y;
                        sx_reg <= shift_x;
                        sy_reg <= shift_y;
                        order_reg <= draw_order;
                        if (int'(orientation) >= ORIENTATIONS)
                        begin
                            switched <= 1'b0;
                            hide_old <= 1'b0;
                            old_orientation <= '0;
                            old_frame <= '0;
                            new_orientation <= '0;
                            new_frame <= '0;
                            order_out <= '0;
                            screen_x <= '0;
                            screen_y <= '0;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            begin : add_blk
                                logic [AW:0] s;
                                s = {1'b0, acc_mem[orientation[$clog2(ORIENTATIONS > 1 ?
                                    ORIENTATIONS : 2)-1:0]]} + (AW + 1)'(time_value);
                                acc_reg <= s[AW] ? {AW{1'b1}} : s[AW-1:0];
                            end
                            prod_reg <= '0;
                            cnt_reg <= CW'(8);
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (fps_reg[cnt_reg[2:0] - 3'd1])
                    begin
                        prod_reg <= (prod_reg << 1) + PW'(acc_reg);
                    end
                    else
                    begin
                        prod_reg <= prod_reg << 1;
                    end
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= ST_DIV1;
                        cnt_reg <= CW'(PW);
                        rem_reg <= '0;
                        dvs_reg <= PW'(scale_reg);
                        quo_reg <= '0;
                        dvd_reg <= fps_reg[0] ? (prod_reg << 1) + PW'(acc_reg)
                            : prod_reg << 1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DIV1, ST_DIV2, ST_MOD:
                begin
                    if (!trial[PW])
                    begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[PW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[PW-2:0], 1'b0};
                    end
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        if (state_reg == ST_DIV1)
                        begin
                            state_reg <= ST_DECIDE;
                        end
                        else if (state_reg == ST_DIV2)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_PLACE;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    adv_reg <= (scale_reg == '0) ? '0 : quo_reg;
                    if ((scale_reg == '0 || quo_reg == '0) && shown_valid_reg)
                    begin
                        acc_mem[ori_reg] <= acc_reg;
                        switched <= 1'b0;
                        hide_old <= 1'b0;
                        old_orientation <= '0;
                        old_frame <= '0;
                        new_orientation <= '0;
                        new_frame <= '0;
                        order_out <= '0;
                        screen_x <= '0;
                        screen_y <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        begin : h_blk
                            logic [PW-1:0] pm;
                            pm = (scale_reg == '0) ? '0 : (prod_reg - rem_reg[PW-1:0]);
                            dvd_reg <= pm;
                        end
                        rem_reg <= '0;
                        quo_reg <= '0;
                        dvs_reg <= PW'(fps_reg);
                        cnt_reg <= CW'(PW);
                        state_reg <= ST_DIV2;
                    end
                end
                ST_FINISH:
                begin
                    acc_mem[ori_reg] <= acc_reg - ((fps_reg == '0) ? '0 : quo_reg[AW-1:0]);
                    dvd_reg <= mod_sum;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    dvs_reg <= PW'(cnt_eff);
                    cnt_reg <= CW'(PW);
                    state_reg <= ST_MOD;
                end
                ST_PLACE:
                begin
                    frame_reg <= rem_reg[7:0];
                    if (shown_valid_reg && shown_ori_reg == ori_reg
                        && shown_frame_reg == rem_reg[7:0])
                    begin
                        switched <= 1'b0;
                        hide_old <= 1'b0;
                        old_orientation <= '0;
                        old_frame <= '0;
                        new_orientation <= '0;
                        new_frame <= '0;
                        order_out <= '0;
                        screen_x <= '0;
                        screen_y <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        switched <= 1'b1;
                        hide_old <= shown_valid_reg;
                        old_orientation <= shown_valid_reg ? shown_ori_reg : '0;
                        old_frame <= shown_valid_reg ? shown_frame_reg : '0;
                        new_orientation <= ori_reg;
                        new_frame <= rem_reg[7:0];
                        order_out <= order_reg;
                        shown_valid_reg <= 1'b1;
                        shown_ori_reg <= ori_reg;
                        shown_frame_reg <= rem_reg[7:0];
                        px_reg <= px_raw;
                        py_reg <= py_raw;
                        px_done_reg <= 1'b0;
                        state_reg <= ST_DIVP;
                    end
                end
                ST_DIVP:
                begin
                    if (!px_done_reg)
                    begin
                        screen_x <= screen_x_t'(pdiv_q - 17'sd8 + (odd ? 17'sd8 : 17'sd0)
                            + 17'(sx_reg));
                        px_done_reg <= 1'b1;
                    end
                    else
                    begin
                        screen_y <= screen_y_t'(pdiv_q - 17'sd8 + (odd ? 17'sd6 : 17'sd0)
                            + 17'(sy_reg) + 17'(sfap_pkg::Y_BIAS));
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int N_ORI = 6;
    localparam int TILE_N = 100;
    localparam int HEX_N = 200;
    localparam int RANDOM_REQUESTS = 900;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [sfap_pkg::ACC_W-1:0] ACC_SAT = {sfap_pkg::ACC_W{1'b1}};

    typedef struct packed {
        logic [2:0]  ori;
        logic [23:0] tval;
        logic [23:0] tscale;
        logic [7:0]  hx;
        logic [7:0]  hy;
        logic [7:0]  sx;
        logic [7:0]  sy;
        logic [15:0] order;
    } request_t;

    typedef struct packed {
        logic        sw;
        logic        hide;
        logic [2:0]  old_ori;
        logic [7:0]  old_frm;
        logic [2:0]  new_ori;
        logic [7:0]  new_frm;
        logic [15:0] order;
        logic [14:0] sx;
        logic [12:0] sy;
    } frame_update_t;

    typedef struct {
        request_t      req;
        bit            typed;
        frame_update_t typed_upd;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = sfap_pkg::REG_FPS;
    logic [7:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    request_t drv = '0;
    logic switched, hide_old;
    logic [2:0] old_orientation, new_orientation;
    logic [7:0] old_frame, new_frame;
    logic [15:0] order_out;
    logic signed [14:0] screen_x;
    logic signed [12:0] screen_y;

    logic [sfap_pkg::ACC_W-1:0] acc_model [N_ORI];
    logic [7:0] frame_idx_model;
    bit shown_model;
    logic [2:0] shown_ori_model;
    logic [7:0] shown_frm_model;
    logic [7:0] fps_model;
    logic [7:0] count_model;

    frame_update_t expected_updates[$];
    int failures = 0;
    int idle_cycles = 0;
    bit sink_hold = 1'b0;
    bit no_idle = 1'b0;
    table_row_t rows[$];

    sprite_frame_advance_and_place DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .orientation(drv.ori), .time_value(drv.tval), .time_scale(drv.tscale),
        .hex_x(drv.hx), .hex_y(drv.hy), .shift_x(drv.sx), .shift_y(drv.sy),
        .draw_order(drv.order), .out_valid(out_valid), .out_ready(out_ready),
        .switched(switched), .hide_old(hide_old),
        .old_orientation(old_orientation), .old_frame(old_frame),
        .new_orientation(new_orientation), .new_frame(new_frame),
        .order_out(order_out), .screen_x(screen_x), .screen_y(screen_y)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic frame_update_t advance_frame(request_t r);
        frame_update_t u;
        longint unsigned acc;
        longint unsigned prod;
        longint unsigned adv;
        longint unsigned rem;
        longint unsigned handled;
        longint unsigned cnt;
        longint px;
        longint py;
        longint scale;
        bit odd;
        u = '0;
        adv = 0;
        rem = 0;
        handled = 0;
        if (r.ori >= N_ORI)
            return u;
        acc = longint'(acc_model[r.ori]) + r.tval;
        if (acc > ACC_SAT)
            acc = ACC_SAT;
        prod = acc * fps_model;
        if (r.tscale != 0)
        begin
            adv = prod / r.tscale;
            rem = prod % r.tscale;
        end
        if (adv == 0 && shown_model)
        begin
            acc_model[r.ori] = acc;
            return u;
        end
        if (fps_model != 0)
            handled = (prod - rem) / fps_model;
        acc_model[r.ori] = acc - handled;
        cnt = (count_model == 0) ? 1 : count_model;
        frame_idx_model = ((frame_idx_model + adv) % cnt) & 8'hFF;
        if (shown_model && shown_ori_model == r.ori && shown_frm_model == frame_idx_model)
            return u;
        u.sw = 1'b1;
        if (shown_model)
        begin
            u.hide = 1'b1;
            u.old_ori = shown_ori_model;
            u.old_frm = shown_frm_model;
        end
        u.new_ori = r.ori;
        u.new_frm = frame_idx_model;
        u.order = r.order;
        scale = HEX_N / TILE_N;
        if (scale == 0)
            scale = 1;
        odd = r.hx[0];
        px = (48 * longint'(r.hx) + 32 * longint'(r.hy)) / scale;
        py = (24 * longint'(r.hy) + 12 * (TILE_N - 1 - longint'(r.hx))) / scale;
        px = px - 8 + (odd ? 8 : 0) + longint'($signed(r.sx));
        py = py - 8 + (odd ? 6 : 0) + longint'($signed(r.sy)) + sfap_pkg::Y_BIAS;
        u.sx = px[14:0];
        u.sy = py[12:0];
        shown_model = 1'b1;
        shown_ori_model = r.ori;
        shown_frm_model = frame_idx_model;
        return u;
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [7:0] val);
        in_valid <= 1'b0;
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == sfap_pkg::REG_FPS)
            fps_model = val;
        else
            count_model = val;
    endtask

    task automatic send_request(request_t r, bit typed, frame_update_t typed_upd);
        frame_update_t u;
        while (!no_idle && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        drv <= r;
        in_valid <= 1'b1;
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        u = advance_frame(r);
        if (typed && u != typed_upd)
        begin
            $display("%0t table row disagrees: typed %h predicted %h", $time, typed_upd, u);
            failures++;
        end
        expected_updates.push_back(u);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_updates.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    function automatic request_t random_request(bit sane);
        request_t r;
        r.ori = sane ? 3'($urandom_range(N_ORI - 1)) : 3'($urandom_range(7));
        case ($urandom_range(3))
            0: r.tval = 24'($urandom);
            1: r.tval = 24'($urandom_range(0, 300));
            default: r.tval = 24'($urandom_range(0, 200000));
        endcase
        case ($urandom_range(4))
            0: r.tscale = 24'($urandom);
            1: r.tscale = 24'($urandom_range(1, 100));
            2: r.tscale = sane ? 24'd1000 : 24'd0;
            default: r.tscale = 24'd1000000;
        endcase
        if (sane)
        begin
            r.hx = 8'($urandom_range(HEX_N - 1));
            r.hy = 8'($urandom_range(HEX_N - 1));
        end
        else
        begin
            r.hx = 8'($urandom);
            r.hy = 8'($urandom);
        end
        r.sx = 8'($urandom);
        r.sy = 8'($urandom);
        r.order = 16'($urandom);
        return r;
    endfunction

    always @(posedge clk)
    begin
        frame_update_t got;
        frame_update_t want;
        if (out_valid && out_ready)
        begin
            got = {switched, hide_old, old_orientation, old_frame, new_orientation,
                   new_frame, order_out, screen_x, screen_y};
            if (expected_updates.size() == 0)
            begin
                $display("%0t unexpected update %h", $time, got);
                failures++;
            end
            else
            begin
                want = expected_updates.pop_front();
                if (got.sw != want.sw || got.hide != want.hide)
                begin
                    $display("%0t switched/hide_old expected %b%b actual %b%b", $time,
                             want.sw, want.hide, got.sw, got.hide);
                    failures++;
                end
                if (got.old_ori != want.old_ori || got.old_frm != want.old_frm)
                begin
                    $display("%0t old frame expected %0d/%0d actual %0d/%0d", $time,
                             want.old_ori, want.old_frm, got.old_ori, got.old_frm);
                    failures++;
                end
                if (got.new_ori != want.new_ori || got.new_frm != want.new_frm)
                begin
                    $display("%0t new frame expected %0d/%0d actual %0d/%0d", $time,
                             want.new_ori, want.new_frm, got.new_ori, got.new_frm);
                    failures++;
                end
                if (got.order != want.order)
                begin
                    $display("%0t order_out expected %h actual %h", $time,
                             want.order, got.order);
                    failures++;
                end
                if (got.sx != want.sx || got.sy != want.sy)
                begin
                    $display("%0t screen expected %0d,%0d actual %0d,%0d", $time,
                             $signed(want.sx), $signed(want.sy),
                             $signed(got.sx), $signed(got.sy));
                    failures++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog expired", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (sink_hold)
            out_ready <= 1'b0;
        else if (no_idle)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 11);
    end

    initial
    begin
        request_t r;
        frame_update_t none;
        int k;
        none = '0;
        for (k = 0; k < N_ORI; k++)
            acc_model[k] = '0;
        frame_idx_model = '0;
        shown_model = 1'b0;
        shown_ori_model = '0;
        shown_frm_model = '0;
        fps_model = sfap_pkg::FPS_RESET;
        count_model = sfap_pkg::COUNT_RESET;

        // First tick after reset always shows frame 0 of orientation 0 at hex (0,0).
        rows.push_back('{'{3'd0, 24'd0, 24'd1, 8'd0, 8'd0, 8'd0, 8'd0, 16'h1234}, 1'b1,
                         '{1'b1, 1'b0, 3'd0, 8'd0, 3'd0, 8'd0, 16'h1234,
                           15'(-8), 13'(1162)}});
        rows.push_back('{'{3'd6, 24'd5, 24'd1, 8'd1, 8'd1, 8'd0, 8'd0, 16'hFFFF}, 1'b1, none});
        rows.push_back('{'{3'd7, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 8'h7F, 8'h80,
                          16'h0}, 1'b1, none});
        rows.push_back('{'{3'd0, 24'd0, 24'd0, 8'd5, 8'd5, 8'd0, 8'd0, 16'd1}, 1'b1, none});
        rows.push_back('{'{3'd1, 24'd100, 24'd1000, 8'd199, 8'd199, 8'h7F, 8'h7F,
                          16'hFFFF}, 1'b0, none});
        rows.push_back('{'{3'd5, 24'hFFFFFF, 24'd1, 8'd0, 8'd199, 8'h80, 8'h80, 16'hAAAA},
                         1'b0, none});
        rows.push_back('{'{3'd2, 24'd1, 24'hFFFFFF, 8'd199, 8'd0, 8'h01, 8'hFF, 16'h5555},
                         1'b0, none});
        rows.push_back('{'{3'd3, 24'd7, 24'd1, 8'd198, 8'd2, 8'h00, 8'h00, 16'h0F0F},
                         1'b0, none});
        rows.push_back('{'{3'd4, 24'd3, 24'd1, 8'd254, 8'd255, 8'h55, 8'hAA, 16'hF0F0},
                         1'b0, none});

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_request(rows[i].req, rows[i].typed, rows[i].typed_upd);
        drain();

        write_reg(sfap_pkg::REG_COUNT, 8'd255);
        write_reg(sfap_pkg::REG_FPS, 8'd255);
        for (k = 0; k < 6; k++)
        begin
            r = random_request(1'b1);
            send_request(r, 1'b0, none);
        end
        drain();
        write_reg(sfap_pkg::REG_FPS, 8'd0);
        for (k = 0; k < 4; k++)
            send_request(random_request(1'b1), 1'b0, none);
        drain();
        write_reg(sfap_pkg::REG_COUNT, 8'd0);
        write_reg(sfap_pkg::REG_FPS, 8'd1);
        for (k = 0; k < 4; k++)
            send_request(random_request(1'b1), 1'b0, none);
        // Largest elapsed times against the largest scale at the slowest rate.
        for (k = 0; k < 3; k++)
            send_request('{3'd2, 24'hFFFFFF, 24'hFFFFFF, 8'd3, 8'd4, 8'd0, 8'd0, 16'd9},
                         1'b0, none);
        drain();

        for (k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k % 150 == 0)
            begin
                drain();
                write_reg(sfap_pkg::REG_FPS, 8'($urandom_range(1, 255)));
                write_reg(sfap_pkg::REG_COUNT, 8'($urandom_range(1, 12)));
            end
            if (k == 300)
                no_idle = 1'b1;
            if (k == 400)
                no_idle = 1'b0;
            if (k == 500)
            begin
                fork
                    begin
                        sink_hold = 1'b1;
                        repeat (600) @(negedge clk);
                        sink_hold = 1'b0;
                    end
                join_none
            end
            send_request(random_request($urandom_range(9) != 0), 1'b0, none);
        end
        drain();

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

[filelist.f]
src/sfap_pkg.sv
src/sprite_frame_advance_and_place.sv
tb/testbench.sv
